/* rtl/interpolated_delay_line_with_pluck_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATED_DELAY_LINE_WITH_PLUCK_CORE_ASSERT_SVH
`define INTERPOLATED_DELAY_LINE_WITH_PLUCK_CORE_ASSERT_SVH

// same-cycle implication
`define IDLWP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("idlwp assertion failed");

// next-cycle implication
`define IDLWP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("idlwp assertion failed");

`endif

/* rtl/idlwp_pkg.sv */
// ----------------------------------------------------------------------------
// idlwp_pkg
// Shared types and codes of the interpolated delay line core.
// ----------------------------------------------------------------------------
package idlwp_pkg;

  localparam logic [1:0] ActSample = 2'd0;
  localparam logic [1:0] ActRamp   = 2'd1;
  localparam logic [1:0] ActPluck  = 2'd2;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhRise = 2'd1;
  localparam logic [1:0] PhFall = 2'd2;

  localparam logic [1:0] MulInterp = 2'd0;
  localparam logic [1:0] MulDelay  = 2'd1;
  localparam logic [1:0] MulPluck  = 2'd2;

  localparam logic [1:0] DivRamp = 2'd0;
  localparam logic [1:0] DivRise = 2'd1;
  localparam logic [1:0] DivFall = 2'd2;

  typedef struct packed {
    logic       clr_en;
    logic       in_ld;
    logic       rd_sel;
    logic       s0_ld;
    logic       mul_ld;
    logic [1:0] mul_sel;
    logic       y_ld;
    logic       env_upd;
    logic       wr;
    logic       ramp_upd;
    logic       tap_ld;
    logic       out_ld;
    logic       div_start;
    logic [1:0] div_sel;
    logic       ramp_ld;
    logic       rise_ld;
    logic       fall_ld;
    logic       pluck_go;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       in_valid;
    logic [1:0] in_act;
    logic       rs_zero;
    logic       p_zero;
    logic       fd_zero;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

/* rtl/idlwp_div.sv */
// ----------------------------------------------------------------------------
// idlwp_div
// Restoring divider, one quotient bit per cycle, signed 32-bit saturated result.
// ----------------------------------------------------------------------------
module idlwp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  input  logic        neg_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [47:0] quo_q;
  logic [31:0] dvs_q;
  logic        neg_q;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[47]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd48;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      quo_q <= {quo_q[46:0], fits};
    end
  end

  always_comb begin
    if (neg_q) begin
      quot_o = (quo_q > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-quo_q[31:0]);
    end else begin
      quot_o = (quo_q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : quo_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

/* rtl/idlwp_dp.sv */
// ----------------------------------------------------------------------------
// idlwp_dp
// Datapath: delay line memory, shared multiplier, divider, envelope and ramp.
// ----------------------------------------------------------------------------
module idlwp_dp #(
  parameter int unsigned LINE_LENGTH = 4096,
  localparam int unsigned IW = $clog2(LINE_LENGTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  idlwp_pkg::cmd_t cmd_i,
  output idlwp_pkg::sts_t sts_o,
  input  logic            s_axis_tvalid_i,
  input  logic [111:0]    s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [15:0]     m_axis_tdata_o
);

  localparam logic [IW:0]   LenW  = (IW + 1)'(LINE_LENGTH);
  localparam logic [IW-1:0] LastI = IW'(LINE_LENGTH - 1);

  logic [15:0] mem [LINE_LENGTH];
  logic [15:0] rd_q;

  logic [IW-1:0] clr_q;
  logic [IW-1:0] widx_q;
  logic [27:0]   dly_q;
  logic [28:0]   inc_q;
  logic [15:0]   rem_q;
  logic [IW-1:0] tapw_q;
  logic [15:0]   tapf_q;
  logic [1:0]    ph_q;
  logic [31:0]   lvl_q;
  logic [15:0]   peak_q;
  logic [31:0]   rise_q;
  logic [31:0]   fall_q;

  logic [15:0] x_q;
  logic [14:0] mod_q;
  logic [27:0] tgt_q;
  logic [15:0] rs_q;
  logic [15:0] amp_q;
  logic [16:0] pos_q;
  logic [15:0] s0_q;
  logic signed [50:0] prod_q;
  logic [15:0] y_q;
  logic        out_v_q;
  logic [15:0] out_q;

  // read addressing
  logic [IW:0]   diff;
  logic [IW:0]   i0w;
  logic [IW-1:0] i0;
  logic [IW-1:0] i1;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  logic [15:0]   wdata;

  assign diff = {1'b0, widx_q} - {1'b0, tapw_q};
  assign i0w  = diff[IW] ? diff + LenW : diff;
  assign i0   = i0w[IW-1:0];
  assign i1   = (i0 == '0) ? LastI : i0 - IW'(1);
  assign raddr = cmd_i.rd_sel ? i1 : i0;

  // multiplier
  logic [16:0]        dsub;
  logic [16:0]        modp;
  logic [16:0]        posc;
  logic [31:0]        lenv;
  logic signed [17:0] mul_a;
  logic [31:0]        mul_b;

  assign dsub = {rd_q[15], rd_q} - {s0_q[15], s0_q};
  assign modp = {mod_q[14], mod_q[14], mod_q} + 17'd16384;
  assign posc = (pos_q > 17'd65536) ? 17'd65536 : pos_q;
  assign lenv = {16'(tapw_q), tapf_q};

  always_comb begin
    unique case (cmd_i.mul_sel)
      idlwp_pkg::MulInterp: begin
        mul_a = {dsub[16], dsub};
        mul_b = {16'd0, tapf_q};
      end
      idlwp_pkg::MulDelay: begin
        mul_a = {1'b0, modp};
        mul_b = {4'd0, dly_q};
      end
      default: begin
        mul_a = {1'b0, posc};
        mul_b = lenv;
      end
    endcase
  end

  // interpolated output
  logic signed [50:0] rnd;
  logic [17:0]        yfull;
  logic [15:0]        ysat;

  assign rnd   = prod_q + 51'sd32768;
  assign yfull = {{2{s0_q[15]}}, s0_q} + 18'(rnd >>> 16);
  assign ysat  = (yfull[17] != yfull[15]) ? (yfull[17] ? 16'h8000 : 16'h7FFF) : yfull[15:0];

  // envelope
  logic [32:0] rsum;
  logic [32:0] fsub;
  logic [31:0] rsat;
  logic [31:0] fsat;
  logic [31:0] peakv;
  logic [32:0] e33;
  logic [16:0] env;
  logic [17:0] wsum;
  logic [15:0] wsat;

  assign rsum  = {lvl_q[31], lvl_q} + {rise_q[31], rise_q};
  assign fsub  = {lvl_q[31], lvl_q} - {fall_q[31], fall_q};
  assign rsat  = (rsum[32] != rsum[31]) ? (rsum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                        : rsum[31:0];
  assign fsat  = (fsub[32] != fsub[31]) ? (fsub[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                        : fsub[31:0];
  assign peakv = {peak_q, 16'd0};
  assign e33   = {lvl_q[31], lvl_q} + 33'd32768;
  assign env   = e33[32:16];
  assign wsum  = {{2{x_q[15]}}, x_q} + {env[16], env};
  assign wsat  = (wsum[17] != wsum[15]) ? (wsum[17] ? 16'h8000 : 16'h7FFF) : wsum[15:0];

  // ramp
  logic [30:0] dsum;
  logic [27:0] dnext;
  logic [28:0] ramp_gap;
  logic [27:0] dmag;

  assign dsum     = {3'd0, dly_q} + {{2{inc_q[28]}}, inc_q};
  assign dnext    = dsum[30] ? 28'd0 : (dsum[29:28] != 2'd0 ? 28'hFFF_FFFF : dsum[27:0]);
  assign ramp_gap = {1'b0, tgt_q} - {1'b0, dly_q};
  assign dmag     = ramp_gap[28] ? 28'(-ramp_gap) : ramp_gap[27:0];

  // tap
  logic [28:0] dmod;
  logic [12:0] whole;
  logic [16:0] whole_x;
  logic        too_long;

  assign dmod     = prod_q[42:14];
  assign whole    = dmod[28:16];
  assign whole_x  = {4'd0, whole};
  assign too_long = whole_x >= 17'(LINE_LENGTH);

  // pluck
  logic [31:0] pval;
  logic [31:0] fdist;
  logic [15:0] amag;

  assign pval  = prod_q[47:16];
  assign fdist = lenv - pval;
  assign amag  = amp_q[15] ? 16'(-amp_q) : amp_q;

  // divider
  logic [47:0] div_n;
  logic [31:0] div_d;
  logic        div_neg;
  logic        div_done;
  logic [31:0] div_q;

  always_comb begin
    unique case (cmd_i.div_sel)
      idlwp_pkg::DivRamp: begin
        div_n   = 48'(dmag);
        div_d   = {16'd0, rs_q};
        div_neg = ramp_gap[28];
      end
      idlwp_pkg::DivRise: begin
        div_n   = {amag, 32'd0};
        div_d   = pval;
        div_neg = amp_q[15];
      end
      default: begin
        div_n   = {amag, 32'd0};
        div_d   = fdist;
        div_neg = amp_q[15];
      end
    endcase
  end

  idlwp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .neg_i      (div_neg),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // memory
  assign we    = cmd_i.clr_en | cmd_i.wr;
  assign waddr = cmd_i.clr_en ? clr_q : widx_q;
  assign wdata = cmd_i.clr_en ? 16'd0 : wsat;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ld) begin
      x_q   <= s_axis_tdata_i[17:2];
      mod_q <= s_axis_tdata_i[32:18];
      tgt_q <= s_axis_tdata_i[60:33];
      rs_q  <= s_axis_tdata_i[76:61];
      amp_q <= s_axis_tdata_i[92:77];
      pos_q <= s_axis_tdata_i[109:93];
    end
    if (cmd_i.s0_ld) begin
      s0_q <= rd_q;
    end
    if (cmd_i.mul_ld) begin
      prod_q <= mul_a * $signed({1'b0, mul_b});
    end
    if (cmd_i.y_ld) begin
      y_q <= ysat;
    end
    if (cmd_i.out_ld) begin
      out_q <= y_q;
    end
  end

  // model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      widx_q  <= '0;
      dly_q   <= '0;
      inc_q   <= '0;
      rem_q   <= '0;
      tapw_q  <= '0;
      tapf_q  <= '0;
      ph_q    <= idlwp_pkg::PhIdle;
      lvl_q   <= '0;
      peak_q  <= '0;
      rise_q  <= '0;
      fall_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + IW'(1);
      end
      if (cmd_i.env_upd) begin
        if (ph_q == idlwp_pkg::PhRise) begin
          if ($signed(rsat) >= $signed(peakv)) begin
            lvl_q <= peakv;
            ph_q  <= idlwp_pkg::PhFall;
          end else begin
            lvl_q <= rsat;
          end
        end else if (ph_q == idlwp_pkg::PhFall) begin
          if ($signed(fsat) <= 32'sd0) begin
            lvl_q <= '0;
            ph_q  <= idlwp_pkg::PhIdle;
          end else begin
            lvl_q <= fsat;
          end
        end
      end
      if (cmd_i.ramp_upd && (rem_q != '0)) begin
        dly_q <= dnext;
        rem_q <= rem_q - 16'd1;
      end
      if (cmd_i.tap_ld) begin
        tapw_q <= too_long ? LastI : whole_x[IW-1:0];
        tapf_q <= too_long ? 16'd0 : dmod[15:0];
        widx_q <= (widx_q == LastI) ? '0 : widx_q + IW'(1);
      end
      if (cmd_i.ramp_ld) begin
        inc_q <= (rs_q == '0) ? ramp_gap : div_q[28:0];
        rem_q <= (rs_q == '0) ? 16'd1 : rs_q;
      end
      if (cmd_i.rise_ld) begin
        rise_q <= (pval == '0) ? {amp_q, 16'd0} : div_q;
      end
      if (cmd_i.fall_ld) begin
        fall_q <= (fdist == '0) ? {amp_q, 16'd0} : div_q;
      end
      if (cmd_i.pluck_go) begin
        peak_q <= amp_q;
        ph_q   <= idlwp_pkg::PhRise;
      end
      if (cmd_i.out_ld) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_done = (clr_q == LastI);
  assign sts_o.in_valid = s_axis_tvalid_i;
  assign sts_o.in_act   = s_axis_tdata_i[1:0];
  assign sts_o.rs_zero  = (rs_q == '0);
  assign sts_o.p_zero   = (pval == '0);
  assign sts_o.fd_zero  = (fdist == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_v_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

endmodule

/* rtl/idlwp_ctrl.sv */
// ----------------------------------------------------------------------------
// idlwp_ctrl
// Sequencer: clearing pass, sample, ramp and pluck command sequences.
// ----------------------------------------------------------------------------
`include "interpolated_delay_line_with_pluck_core_assert.svh"

module idlwp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  idlwp_pkg::sts_t sts_i,
  output idlwp_pkg::cmd_t cmd_o,
  output logic            s_axis_tready_o
);

  localparam logic [4:0] SClear  = 5'd0;
  localparam logic [4:0] SIdle   = 5'd1;
  localparam logic [4:0] SRd0    = 5'd2;
  localparam logic [4:0] SRd1    = 5'd3;
  localparam logic [4:0] SMulI   = 5'd4;
  localparam logic [4:0] SYout   = 5'd5;
  localparam logic [4:0] SWr     = 5'd6;
  localparam logic [4:0] SMulD   = 5'd7;
  localparam logic [4:0] STap    = 5'd8;
  localparam logic [4:0] SOut    = 5'd9;
  localparam logic [4:0] SRSet   = 5'd10;
  localparam logic [4:0] SRWait  = 5'd11;
  localparam logic [4:0] SPMul   = 5'd12;
  localparam logic [4:0] SPRise  = 5'd13;
  localparam logic [4:0] SPRWait = 5'd14;
  localparam logic [4:0] SPFall  = 5'd15;
  localparam logic [4:0] SPFWait = 5'd16;

  logic [4:0] state_q;
  logic [4:0] state_d;
  logic       accept;

  assign s_axis_tready_o = (state_q == SIdle);
  assign accept          = s_axis_tready_o && sts_i.in_valid;

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = idlwp_pkg::MulInterp;
    cmd_o.div_sel = idlwp_pkg::DivRamp;
    cmd_o.in_ld   = accept;
    state_d       = state_q;
    unique case (state_q)
      SClear: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_done) state_d = SIdle;
      end
      SIdle: begin
        if (accept) begin
          if (sts_i.in_act == idlwp_pkg::ActSample) state_d = SRd0;
          else if (sts_i.in_act == idlwp_pkg::ActRamp) state_d = SRSet;
          else if (sts_i.in_act == idlwp_pkg::ActPluck) state_d = SPMul;
        end
      end
      SRd0: state_d = SRd1;
      SRd1: begin
        cmd_o.rd_sel = 1'b1;
        cmd_o.s0_ld  = 1'b1;
        state_d      = SMulI;
      end
      SMulI: begin
        cmd_o.mul_ld = 1'b1;
        state_d      = SYout;
      end
      SYout: begin
        cmd_o.y_ld    = 1'b1;
        cmd_o.env_upd = 1'b1;
        state_d       = SWr;
      end
      SWr: begin
        cmd_o.wr       = 1'b1;
        cmd_o.ramp_upd = 1'b1;
        state_d        = SMulD;
      end
      SMulD: begin
        cmd_o.mul_ld  = 1'b1;
        cmd_o.mul_sel = idlwp_pkg::MulDelay;
        state_d       = STap;
      end
      STap: begin
        cmd_o.tap_ld = 1'b1;
        state_d      = SOut;
      end
      SOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = SIdle;
        end
      end
      SRSet: begin
        if (sts_i.rs_zero) begin
          cmd_o.ramp_ld = 1'b1;
          state_d       = SIdle;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = SRWait;
        end
      end
      SRWait: begin
        if (sts_i.div_done) begin
          cmd_o.ramp_ld = 1'b1;
          state_d       = SIdle;
        end
      end
      SPMul: begin
        cmd_o.mul_ld  = 1'b1;
        cmd_o.mul_sel = idlwp_pkg::MulPluck;
        state_d       = SPRise;
      end
      SPRise: begin
        cmd_o.div_sel = idlwp_pkg::DivRise;
        if (sts_i.p_zero) begin
          cmd_o.rise_ld = 1'b1;
          state_d       = SPFall;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = SPRWait;
        end
      end
      SPRWait: begin
        cmd_o.div_sel = idlwp_pkg::DivRise;
        if (sts_i.div_done) begin
          cmd_o.rise_ld = 1'b1;
          state_d       = SPFall;
        end
      end
      SPFall: begin
        cmd_o.div_sel = idlwp_pkg::DivFall;
        if (sts_i.fd_zero) begin
          cmd_o.fall_ld  = 1'b1;
          cmd_o.pluck_go = 1'b1;
          state_d        = SIdle;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = SPFWait;
        end
      end
      SPFWait: begin
        cmd_o.div_sel = idlwp_pkg::DivFall;
        if (sts_i.div_done) begin
          cmd_o.fall_ld  = 1'b1;
          cmd_o.pluck_go = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
    end else begin
      state_q <= state_d;
    end
  end

  `IDLWP_ASSERT_NOW(a_out_free, cmd_o.out_ld, sts_i.out_free)
  `IDLWP_ASSERT_NEXT(a_sample_seq, accept && (sts_i.in_act == idlwp_pkg::ActSample),
                     state_q == SRd0)
  `IDLWP_ASSERT_NEXT(a_div_wait, cmd_o.div_start,
                     (state_q == SRWait) || (state_q == SPRWait) || (state_q == SPFWait))
  `IDLWP_ASSERT_NOW(a_no_wr_clear, cmd_o.wr, !cmd_o.clr_en && !s_axis_tready_o)

endmodule

/* rtl/interpolated_delay_line_with_pluck_core.sv */
// ----------------------------------------------------------------------------
// interpolated_delay_line_with_pluck_core
// Fractional delay line with linear interpolation and triangular pluck.
// ----------------------------------------------------------------------------
// Input requests arrive on s_axis; action 0 is an audio sample, 1 sets a
// delay target with a ramp, 2 starts a pluck, 3 is dropped.
// Each sample request gives one interpolated sample on m_axis; the other
// actions give nothing.
// One request is in flight at a time. A sample passes through SRd0, SRd1,
// SMulI, SYout, SWr, SMulD, STap and SOut (two line reads, two passes
// through the shared multiplier); SOut waits for the output register to
// be free, and m_axis_tvalid_o rises as the input is ready again. A ramp
// request holds the input through SRSet, and with a ramp length also
// through SRWait (48-step serial divider). A pluck holds it for one
// multiply and up to two serial divides. After reset the line memory is
// cleared one entry per cycle, all LINE_LENGTH entries, with s_axis_tready_o low.
// The output is a register: a new request is accepted while a result
// waits; a sample that completes while m_axis is stalled holds until taken.
// ----------------------------------------------------------------------------
module interpolated_delay_line_with_pluck_core #(
  parameter int unsigned LINE_LENGTH = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // action[1:0], sample_in[17:2], modulation[32:18], target_delay[60:33],
  // ramp_samples[76:61], pluck_amplitude[92:77], pluck_position[109:93]
  input  logic [111:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // sample_out[15:0]
  output logic [15:0]  m_axis_tdata_o
);

  idlwp_pkg::cmd_t cmd;
  idlwp_pkg::sts_t sts;

  idlwp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .s_axis_tready_o (s_axis_tready_o)
  );

  idlwp_dp #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interpolated delay line core: drives sample,
// ramp, pluck and dropped requests, predicts each output sample in a
// scoreboard with its own delay line and envelope state, and compares.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineLen = 4096;
  localparam logic [1:0] ActSample = idlwp_pkg::ActSample;
  localparam logic [1:0] ActRamp   = idlwp_pkg::ActRamp;
  localparam logic [1:0] ActPluck  = idlwp_pkg::ActPluck;
  localparam logic [1:0] ActDrop   = 2'd3;
  localparam logic [1:0] PhIdle    = idlwp_pkg::PhIdle;
  localparam logic [1:0] PhRise    = idlwp_pkg::PhRise;
  localparam logic [1:0] PhFall    = idlwp_pkg::PhFall;
  localparam longint     I32Min    = -64'sd2147483648;
  localparam longint     I32Max    = 64'sd2147483647;

  class delay_scoreboard;
    logic signed [15:0] line_mem[LineLen];
    int unsigned        wr_idx;
    longint             delay_q;
    longint             ramp_inc;
    int unsigned        ramp_left;
    int unsigned        tap_int;
    int unsigned        tap_frac;
    logic [1:0]         phase;
    longint             level;
    longint             peak;
    longint             rise_step;
    longint             fall_step;
    logic [15:0]        pending[$];
    int                 errors;

    function new();
      for (int k = 0; k < LineLen; k++) line_mem[k] = '0;
      wr_idx = 0; delay_q = 0; ramp_inc = 0; ramp_left = 0;
      tap_int = 0; tap_frac = 0; phase = PhIdle; level = 0; peak = 0;
      rise_step = 0; fall_step = 0; errors = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint fshr16(longint v);
      if (v >= 0) return v >>> 16;
      return -((-v + 65535) >>> 16);
    endfunction

    function longint env_step(longint amp, longint span);
      if (span > 0) return clip((amp * 64'sd4294967296) / span, I32Min, I32Max);
      return amp * 65536;
    endfunction

    function void note_request(logic [111:0] d);
      logic [1:0] act;
      longint x, m, tgt, len, pos, p, acc, y, env, dl;
      int unsigned rs, i0, i1;
      act = d[1:0];
      if (act == ActRamp) begin
        tgt = longint'(d[60:33]);
        rs = 32'(d[76:61]);
        if (rs == 0) begin
          ramp_inc = tgt - delay_q; ramp_left = 1;
        end else begin
          ramp_inc = (tgt - delay_q) / longint'(rs); ramp_left = rs;
        end
      end else if (act == ActPluck) begin
        pos = longint'(d[109:93]);
        if (pos > 65536) pos = 65536;
        len = (longint'(tap_int) << 16) + longint'(tap_frac);
        p = (pos * len) >>> 16;
        peak = longint'($signed(d[92:77]));
        rise_step = env_step(peak, p);
        fall_step = env_step(peak, len - p);
        phase = PhRise;
      end else if (act == ActSample) begin
        x = longint'($signed(d[17:2]));
        m = longint'($signed(d[32:18]));
        i0 = (wr_idx + LineLen - tap_int) % LineLen;
        i1 = (wr_idx + 2 * LineLen - tap_int - 1) % LineLen;
        acc = longint'(line_mem[i0]) * (65536 - longint'(tap_frac))
            + longint'(line_mem[i1]) * longint'(tap_frac);
        y = clip(fshr16(acc + 32768), -32768, 32767);
        pending.push_back(y[15:0]);
        if (phase == PhRise) begin
          level = clip(level + rise_step, I32Min, I32Max);
          if (level >= peak * 65536) begin
            level = peak * 65536; phase = PhFall;
          end
        end else if (phase == PhFall) begin
          level = clip(level - fall_step, I32Min, I32Max);
          if (level <= 0) begin
            level = 0; phase = PhIdle;
          end
        end
        env = (phase == PhIdle && level == 0) ? 0 : fshr16(level + 32768);
        line_mem[wr_idx] = 16'(clip(x + env, -32768, 32767));
        if (ramp_left > 0) begin
          delay_q = clip(delay_q + ramp_inc, 0, 268435455); ramp_left--;
        end
        dl = (delay_q * (16384 + m)) >>> 14;
        if (dl < 0) dl = 0;
        if ((dl >>> 16) >= LineLen) begin
          tap_int = LineLen - 1; tap_frac = 0;
        end else begin
          tap_int = int'(dl >>> 16); tap_frac = int'(dl & 65535);
        end
        wr_idx = (wr_idx + 1) % LineLen;
      end
    endfunction

    function void check_sample(logic [15:0] got);
      logic [15:0] exp_v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected sample_out %0d", $time, $signed(got));
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got !== exp_v) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, $signed(exp_v),
                 $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [111:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [15:0]  m_axis_tdata_o;

  delay_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  interpolated_delay_line_with_pluck_core #(.LINE_LENGTH(LineLen)) dut (.*);

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) sb.note_request(s_axis_tdata_i);
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_sample(m_axis_tdata_o);
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [111:0] pack_req(logic [1:0] act, logic [15:0] smp,
      logic [14:0] md, logic [27:0] tgt, logic [15:0] rs, logic [15:0] amp,
      logic [16:0] pos);
    return {2'b00, pos, amp, rs, tgt, md, smp, act};
  endfunction

  // tvalid stays high after an accept so requests can follow back to back
  task automatic send_req(logic [111:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int r;
    logic [15:0] smp, amp;
    logic [14:0] md;
    logic [27:0] tgt;
    logic [15:0] rs;
    logic [16:0] pos;
    r = $urandom_range(99);
    smp = 16'($urandom);
    md = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(1023) - 512);
    tgt = ($urandom_range(3) == 0) ? 28'($urandom) : 28'($urandom_range(40 << 16));
    rs = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    amp = 16'($urandom);
    pos = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    if (r < 84) send_req(pack_req(ActSample, smp, md, tgt, rs, amp, pos));
    else if (r < 91) send_req(pack_req(ActRamp, smp, md, tgt, rs, amp, pos));
    else if (r < 98) send_req(pack_req(ActPluck, smp, md, tgt, rs, amp, pos));
    else send_req(pack_req(ActDrop, smp, md, tgt, rs, amp, pos));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (120) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_req(pack_req(ActSample, 16'h7fff, 15'h0, '0, '0, '0, '0));
    send_req(pack_req(ActSample, 16'h8000, 15'h3fff, '0, '0, '0, '0));
    send_req(pack_req(ActRamp, '0, '0, 28'd3 << 16, 16'd0, '0, '0));
    send_req(pack_req(ActSample, 16'h1234, 15'h0, '0, '0, '0, '0));
    send_req(pack_req(ActSample, 16'h8000, 15'h4000, '0, '0, '0, '0));
    send_req(pack_req(ActSample, 16'h7fff, 15'h3fff, '0, '0, '0, '0));
    send_req(pack_req(ActSample, 16'h0100, 15'h0, '0, '0, '0, '0));
    send_req(pack_req(ActPluck, '0, '0, '0, '0, 16'h7fff, 17'h1ffff));
    send_req(pack_req(ActSample, 16'h7fff, 15'h0, '0, '0, '0, '0));
    send_req(pack_req(ActPluck, '0, '0, '0, '0, 16'h8000, 17'd0));
    send_req(pack_req(ActSample, 16'h8000, 15'h0, '0, '0, '0, '0));
    send_req(pack_req(ActDrop, 16'hffff, 15'h7fff, 28'hfffffff, 16'hffff, 16'hffff,
                      17'h1ffff));
    send_req(pack_req(ActRamp, '0, '0, 28'hfffffff, 16'd3, '0, '0));
    repeat (4) send_req(pack_req(ActSample, 16'h5555, 15'h0, '0, '0, '0, '0));
    send_req(pack_req(ActPluck, '0, '0, '0, '0, 16'h4000, 17'h10000));
    send_req(pack_req(ActSample, 16'haaaa, 15'h3fff, '0, '0, '0, '0));
    send_req(pack_req(ActRamp, '0, '0, 28'd0, 16'hffff, '0, '0));
    send_req(pack_req(ActRamp, '0, '0, 28'd17 << 15, 16'd7, '0, '0));
    repeat (3) send_req(pack_req(ActSample, 16'h0, 15'h0, '0, '0, '0, '0));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 75 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 25 : 75) : 0;
      if (ph == 3) send_idle_pct = 25;
      if (ph == 0) begin
        fork
          begin
            @(negedge clk_i);
            hold_off = 1'b1;
            repeat (300) @(negedge clk_i);
            hold_off = 1'b0;
          end
          repeat (40) send_random();
        join
      end
      repeat (420) send_random();
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end
endmodule
